### rtl/core/pli_pkg.sv
package pli_pkg;

    localparam int unsigned PROB_BITS_DEF = 16;
    localparam int unsigned CFG_ADDR_W    = 2;
    localparam int unsigned OUT_TDATA_W   = 8;
    localparam int unsigned IVL_W         = 16;
    localparam int unsigned RAMP_W        = 9;

    localparam logic [IVL_W-1:0]  INTERVAL_MAX = 16'hFFFF;
    localparam logic [RAMP_W-1:0] RAMP_LEN     = 9'd300;

    // gilbert thresholds as fractions over ten, burst entry scale on the rate
    localparam int unsigned GE_DEN      = 10;
    localparam int unsigned GE_EXIT_NUM = 3;
    localparam int unsigned GE_CAP_NUM  = 8;
    localparam int unsigned GE_RATE_MUL = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOSS_RATE = 2'd0,
        REG_LOSS_MODE = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_RANDOM   = 2'd0,
        MODE_GILBERT  = 2'd1,
        MODE_PERIODIC = 2'd2,
        MODE_GRADUAL  = 2'd3
    } loss_mode_t;

    typedef struct packed {
        logic              in_burst;
        logic [IVL_W-1:0]  period_count;
        logic [RAMP_W-1:0] ramp_count;
    } run_state_t;

endpackage

### rtl/core/pli_interval_div.sv
module pli_interval_div
    import pli_pkg::*;
#(
    parameter int unsigned PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROB_BITS:0]   rate,
    output logic                 busy,
    output logic [IVL_W-1:0]     interval
);

    localparam int unsigned CW = $clog2(PROB_BITS + 1);
    localparam int unsigned QW = (PROB_BITS + 1 > IVL_W + 1) ? PROB_BITS + 1 : IVL_W + 1;

    logic [PROB_BITS:0]   rem_reg;
    logic [PROB_BITS:0]   q_reg;
    logic [PROB_BITS:0]   divisor_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic [IVL_W-1:0]     interval_reg;

    logic [PROB_BITS+1:0] rem_sh;
    logic [PROB_BITS+1:0] rem_diff;
    logic                 ge;
    logic [PROB_BITS:0]   rem_next;
    logic [PROB_BITS:0]   q_next;
    logic [QW-1:0]        q_ext;
    logic [IVL_W-1:0]     interval_next;

    // restoring division of one (1 << PROB_BITS) by the rate, one quotient bit a cycle
    always_comb
    begin
        rem_sh   = {rem_reg, (cnt_reg == CW'(PROB_BITS))};
        rem_diff = rem_sh - {1'b0, divisor_reg};
        ge       = (rem_sh >= {1'b0, divisor_reg});
        rem_next = ge ? rem_diff[PROB_BITS:0] : rem_sh[PROB_BITS:0];
        q_next   = {q_reg[PROB_BITS-1:0], ge};
        q_ext    = QW'(q_next);
        if (q_ext > QW'(INTERVAL_MAX))
        begin
            interval_next = INTERVAL_MAX;
        end
        else if (q_ext == '0)
        begin
            interval_next = IVL_W'(1);
        end
        else
        begin
            interval_next = q_ext[IVL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            interval_reg <= INTERVAL_MAX;
            rem_reg      <= '0;
            q_reg        <= '0;
            divisor_reg  <= '0;
            cnt_reg      <= '0;
        end
        else if (start)
        begin
            rem_reg     <= '0;
            q_reg       <= '0;
            divisor_reg <= rate;
            cnt_reg     <= CW'(PROB_BITS);
            if (rate == '0)
            begin
                busy_reg     <= 1'b0;
                interval_reg <= INTERVAL_MAX;
            end
            else
            begin
                busy_reg <= 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (cnt_reg == '0)
            begin
                busy_reg     <= 1'b0;
                interval_reg <= interval_next;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign busy     = busy_reg;
    assign interval = interval_reg;

endmodule

### rtl/core/pli_decide.sv
module pli_decide
    import pli_pkg::*;
#(
    parameter int unsigned PROB_BITS = PROB_BITS_DEF
)
(
    input  loss_mode_t             mode,
    input  logic [PROB_BITS:0]     rate,
    input  logic [IVL_W-1:0]       interval,
    input  logic                   run_start,
    input  logic [PROB_BITS-1:0]   sample,
    input  run_state_t             state_in,
    output logic                   drop,
    output run_state_t             state_out
);

    localparam int unsigned GW = PROB_BITS + 4;
    localparam int unsigned MW = PROB_BITS + RAMP_W + 2;

    run_state_t        st;
    logic [GW-1:0]     s10;
    logic [GW-1:0]     rate3;
    logic [IVL_W-1:0]  cnt1;
    logic [MW-1:0]     lhs;
    logic [MW-1:0]     rhs;

    always_comb
    begin
        st        = run_start ? '0 : state_in;
        state_out = st;
        drop      = 1'b0;

        s10   = GW'(sample) * GW'(GE_DEN);
        rate3 = GW'(rate) * GW'(GE_RATE_MUL);
        cnt1  = st.period_count + 1'b1;
        lhs   = MW'(sample) * MW'(RAMP_LEN);
        rhs   = (MW'(rate) * MW'(st.ramp_count)) << 1;

        case (mode)
            MODE_RANDOM:
            begin
                drop = ({1'b0, sample} < rate);
            end
            MODE_GILBERT:
            begin
                if (st.in_burst)
                begin
                    if (s10 < (GW'(GE_EXIT_NUM) << PROB_BITS))
                    begin
                        state_out.in_burst = 1'b0;
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
                else if ((GW'(sample) < rate3) && (s10 < (GW'(GE_CAP_NUM) << PROB_BITS)))
                begin
                    state_out.in_burst = 1'b1;
                    drop               = 1'b1;
                end
            end
            MODE_PERIODIC:
            begin
                if (cnt1 >= interval)
                begin
                    state_out.period_count = '0;
                    drop                   = 1'b1;
                end
                else
                begin
                    state_out.period_count = cnt1;
                end
            end
            MODE_GRADUAL:
            begin
                // threshold uses the count before it steps; cap at one half
                if (st.ramp_count < RAMP_LEN)
                begin
                    state_out.ramp_count = st.ramp_count + 1'b1;
                end
                drop = (lhs < rhs) && !sample[PROB_BITS-1];
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/packet_loss_injector_top.sv
// an accepted item is registered in the input register; its decision then loads the result
// register once that register is free or being read
// throughput: one item per cycle while m_axis_tready is high, cfg_valid is low and the
// divider is idle; a waiting result holds off input once the input register is also full
// a rate write recomputes the periodic interval in a bit-serial divider; input is held
// off while it runs (the divider does not run when the rate is zero)
// reset: rst_n is asynchronous, clears rate, mode, burst flag and counters, interval to 65535
module packet_loss_injector_top
    import pli_pkg::*;
#(
    parameter int unsigned PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((PROB_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // uniform_sample
    input  logic                                s_axis_tuser,  // run_start

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [OUT_TDATA_W-1:0]              m_axis_tdata,  // drop

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [PROB_BITS:0]                  cfg_data
);

    logic [PROB_BITS:0]     drop_rate_reg;
    loss_mode_t             loss_mode_reg;
    run_state_t             state_reg;

    logic                   in_valid_reg;
    logic                   in_run_start_reg;
    logic [PROB_BITS-1:0]   in_sample_reg;
    logic                   out_valid_reg;
    logic                   drop_reg;

    logic                   cfg_we;
    logic                   rate_we;
    logic                   mode_we;
    logic                   div_busy;
    logic [IVL_W-1:0]       interval;
    logic                   advance;
    logic                   accept;
    logic                   drop_next;
    run_state_t             state_next;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign rate_we   = cfg_we && (cfg_addr == REG_LOSS_RATE);
    assign mode_we   = cfg_we && (cfg_addr == REG_LOSS_MODE);

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (!in_valid_reg || advance) && !div_busy && !cfg_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pli_interval_div #(
        .PROB_BITS (PROB_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rate_we),
        .rate     (cfg_data),
        .busy     (div_busy),
        .interval (interval)
    );

    pli_decide #(
        .PROB_BITS (PROB_BITS)
    ) u_decide (
        .mode      (loss_mode_reg),
        .rate      (drop_rate_reg),
        .interval  (interval),
        .run_start (in_run_start_reg),
        .sample    (in_sample_reg),
        .state_in  (state_reg),
        .drop      (drop_next),
        .state_out (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_rate_reg <= '0;
            loss_mode_reg <= MODE_RANDOM;
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (rate_we)
            begin
                drop_rate_reg <= cfg_data;
            end
            // a mode write wins over any state update
            if (mode_we)
            begin
                loss_mode_reg <= loss_mode_t'(cfg_data[1:0]);
                state_reg     <= '0;
            end
            else if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg    <= s_axis_tdata[PROB_BITS-1:0];
            in_run_start_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            drop_reg <= drop_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(drop_reg);

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !s_axis_tready)
        else $error("input accepted while interval divider busy");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_ramp_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ramp_count <= RAMP_LEN)
        else $error("ramp count past saturation");

    a_mode_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        mode_we |=> (state_reg == '0))
        else $error("mode write did not clear run state");

    a_interval_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        interval != '0)
        else $error("periodic interval is zero");
`endif

endmodule

### tb/sv/testbench.sv
module testbench;
    import pli_pkg::*;

    localparam int unsigned     PB          = PROB_BITS_DEF;
    localparam int unsigned     RW          = PB + 1;
    localparam int unsigned     TDATA_W     = ((PB + 7) / 8) * 8;
    localparam longint unsigned ONE         = 64'd1 << PB;
    localparam logic [PB:0]     RATE_ONE    = RW'(ONE);
    localparam logic [PB:0]     RATE_TOP    = '1;
    localparam logic [PB-1:0]   EXIT_EDGE   = PB'((GE_EXIT_NUM * ONE) / GE_DEN);
    localparam logic [PB-1:0]   CAP_EDGE    = PB'((GE_CAP_NUM * ONE) / GE_DEN);
    localparam logic [PB-1:0]   HALF_EDGE   = PB'(ONE / 2);
    localparam int unsigned     HOLD_CYCLES = 400;
    localparam int unsigned     MAX_PRINTS  = 200;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic          run_start;
        logic [PB-1:0] sample;
    } pkt_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
    logic [PB:0]            cfg_data      = '0;

    // predicted block state
    logic [PB:0]       cur_rate;
    loss_mode_t        cur_mode;
    logic              burst_state;
    logic [IVL_W-1:0]  period_cnt;
    logic [RAMP_W-1:0] ramp_cnt;
    logic [IVL_W-1:0]  period_ivl;

    pkt_t        pending[$];
    logic        drop_q[$];
    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    int unsigned rx_cycle     = 0;
    int unsigned rx_style     = 0;
    logic        rx_hold      = 1'b0;
    logic        hold_request = 1'b0;

    packet_loss_injector_top #(.PROB_BITS(PB)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic decide_drop(input logic run_start, input logic [PB-1:0] s);
        longint unsigned samp;
        longint unsigned rate_w;
        longint unsigned n;
        logic            d;
        samp   = 64'(s);
        rate_w = 64'(cur_rate);
        d      = 1'b0;
        if (run_start)
        begin
            burst_state = 1'b0;
            period_cnt  = '0;
            ramp_cnt    = '0;
        end
        case (cur_mode)
            MODE_RANDOM:
                d = samp < rate_w;
            MODE_GILBERT:
                if (burst_state)
                begin
                    if (GE_DEN * samp < GE_EXIT_NUM * ONE)
                        burst_state = 1'b0;
                    else
                        d = 1'b1;
                end
                else if (samp < GE_RATE_MUL * rate_w && GE_DEN * samp < GE_CAP_NUM * ONE)
                begin
                    burst_state = 1'b1;
                    d           = 1'b1;
                end
            MODE_PERIODIC:
            begin
                period_cnt = period_cnt + 1'b1;
                if (period_cnt >= period_ivl)
                begin
                    period_cnt = '0;
                    d          = 1'b1;
                end
            end
            default:
            begin
                // threshold uses the count before it advances
                n = 64'(ramp_cnt);
                if (ramp_cnt < RAMP_LEN)
                    ramp_cnt = ramp_cnt + 1'b1;
                d = (RAMP_LEN * samp < 64'd2 * rate_w * n) && (64'd2 * samp < ONE);
            end
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic want,
                                   input logic [OUT_TDATA_W-1:0] got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] result %0d: %s, expected drop %0b, got tdata %0h",
                     $time, results_seen, what, want, got);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [PB:0] value);
        longint unsigned q;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (addr == REG_LOSS_RATE)
        begin
            cur_rate = value;
            if (value == '0)
                q = 64'(INTERVAL_MAX);
            else
            begin
                q = ONE / value;
                if (q < 1)
                    q = 1;
                if (q > INTERVAL_MAX)
                    q = 64'(INTERVAL_MAX);
            end
            period_ivl = q[IVL_W-1:0];
        end
        else if (addr == REG_LOSS_MODE)
        begin
            cur_mode    = loss_mode_t'(value[1:0]);
            burst_state = 1'b0;
            period_cnt  = '0;
            ramp_cnt    = '0;
        end
    endtask

    task automatic push_item(input logic run_start, input logic [PB-1:0] sample);
        pending.push_back({run_start, sample});
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending.size() != 0 || drop_q.size() != 0);
    endtask

    // sender: bursts of random length, random gaps, valid held until taken
    always @(posedge clk)
    begin : drive_packets
        pkt_t pkt;
        logic offer;
        offer = 1'b0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pkt = pending.pop_front();
                drop_q.push_back(decide_drop(pkt.run_start, pkt.sample));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 16);
                end
            end
            else if (s_axis_tvalid)
                offer = 1'b1;
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                    offer = pending.size() != 0;
            end
        end
        s_axis_tvalid <= offer;
        if (offer)
        begin
            s_axis_tdata <= TDATA_W'(pending[0].sample);
            s_axis_tuser <= pending[0].run_start;
        end
    end

    // receiver: checks each decision, stalls on a ready pattern chosen at random from four styles
    always @(posedge clk)
    begin : check_decisions
        logic want;
        logic ready_next;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drop_q.size() == 0)
                report_mismatch("decision with no packet outstanding", 1'b0, m_axis_tdata);
            else
            begin
                want = drop_q.pop_front();
                if (m_axis_tdata !== {{(OUT_TDATA_W-1){1'b0}}, want})
                    report_mismatch("wrong drop decision", want, m_axis_tdata);
            end
            results_seen++;
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_style = $urandom_range(0, 3);
        case (rx_style)
            0:       ready_next = 1'b1;
            1:       ready_next = 1'($urandom_range(0, 1));
            2:       ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = (rx_cycle % 5) != 0;
        endcase
        if (rx_hold || !rst_n)
            ready_next = 1'b0;
        m_axis_tready <= ready_next;
    end

    // long output stall so the pipeline backs up into the input
    initial
    begin : hold_off
        wait (hold_request);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : stimulus
        int unsigned     ph;
        int unsigned     i;
        int unsigned     n_items;
        int unsigned     guard;
        logic            long_phase;
        logic            rs;
        logic [PB:0]     rate_pick;
        logic [PB:0]     mode_word;
        logic [PB-1:0]   samp;
        loss_mode_t      mode_pick;

        cur_rate    = '0;
        cur_mode    = MODE_RANDOM;
        burst_state = 1'b0;
        period_cnt  = '0;
        ramp_cnt    = '0;
        period_ivl  = INTERVAL_MAX;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // zero rate after reset never drops
        push_item(1'b0, '0);
        push_item(1'b0, '1);
        wait_drained();

        // rate of one drops everything in random and periodic modes
        cfg_write(REG_LOSS_RATE, RATE_ONE);
        push_item(1'b0, '1);
        push_item(1'b1, '0);
        wait_drained();
        cfg_write(REG_LOSS_MODE, RW'(MODE_PERIODIC));
        push_item(1'b0, '0);
        push_item(1'b0, '1);
        wait_drained();

        // rate above one, interval clamps to one
        cfg_write(REG_LOSS_RATE, RATE_TOP);
        push_item(1'b0, 16'h1234);
        push_item(1'b1, 16'hedcb);
        wait_drained();

        // tiny rate, interval saturates
        cfg_write(REG_LOSS_RATE, RW'(1));
        push_item(1'b0, 16'h00ff);
        wait_drained();

        // zero rate in periodic mode
        cfg_write(REG_LOSS_RATE, '0);
        push_item(1'b0, 16'hff00);
        wait_drained();

        // quarter rate, drop every fourth, restart mid count
        cfg_write(REG_LOSS_RATE, 17'd16384);
        push_item(1'b0, 16'h5555);
        push_item(1'b0, 16'haaaa);
        push_item(1'b0, 16'h0f0f);
        push_item(1'b1, 16'hf0f0);
        push_item(1'b0, 16'h3c3c);
        wait_drained();

        // burst model: enter, stay, exit right at the 0.3 edge, re-enter, restart
        cfg_write(REG_LOSS_MODE, RW'(MODE_GILBERT));
        push_item(1'b0, 16'd100);
        push_item(1'b0, 16'd40000);
        push_item(1'b0, EXIT_EDGE + 1'b1);
        push_item(1'b0, EXIT_EDGE);
        push_item(1'b0, 16'd49151);
        push_item(1'b1, 16'd60000);
        wait_drained();

        // entry threshold capped at 0.8
        cfg_write(REG_LOSS_RATE, RATE_ONE);
        push_item(1'b0, CAP_EDGE);
        push_item(1'b1, CAP_EDGE + 1'b1);
        wait_drained();

        // ramp starts at zero threshold
        cfg_write(REG_LOSS_MODE, RW'(MODE_GRADUAL));
        push_item(1'b0, '0);
        push_item(1'b0, '0);
        push_item(1'b0, HALF_EDGE - 1'b1);
        wait_drained();

        // writes past the register list change nothing
        cfg_write(REG_SPARE_LO, 17'h0a5a5);
        cfg_write(REG_SPARE_HI, RATE_TOP);
        push_item(1'b0, 16'd1);
        wait_drained();

        for (ph = 0; ph < 11; ph++)
        begin
            long_phase = (ph == 5);
            case ($urandom_range(0, 8))
                0:       rate_pick = '0;
                1:       rate_pick = RW'(1);
                2:       rate_pick = RATE_ONE;
                3:       rate_pick = RATE_TOP;
                4:       rate_pick = RATE_ONE - 1'b1;
                5:       rate_pick = RW'($urandom_range(2, 4095));
                6:       rate_pick = RW'($urandom);
                default: rate_pick = RW'($urandom_range(0, RATE_ONE));
            endcase
            mode_pick = loss_mode_t'($urandom_range(0, 3));
            if (long_phase)
            begin
                mode_pick = MODE_GRADUAL;
                rate_pick = RW'($urandom_range(20000, RATE_ONE));
            end
            mode_word      = RW'($urandom);
            mode_word[1:0] = mode_pick;

            case (long_phase ? 0 : $urandom_range(0, 3))
                0:
                begin
                    cfg_write(REG_LOSS_RATE, rate_pick);
                    cfg_write(REG_LOSS_MODE, mode_word);
                end
                1:
                begin
                    cfg_write(REG_LOSS_MODE, mode_word);
                    cfg_write(REG_LOSS_RATE, rate_pick);
                end
                2:       cfg_write(REG_LOSS_RATE, rate_pick);
                default: cfg_write(REG_LOSS_MODE, mode_word);
            endcase
            if ($urandom_range(0, 4) == 0)
                cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, RW'($urandom));

            if (long_phase)
                hold_request = 1'b1;
            n_items = long_phase ? 360 : $urandom_range(50, 120);
            for (i = 0; i < n_items; i++)
            begin
                // long phase runs unbroken so the ramp reaches its ceiling
                rs = long_phase ? (i == 0) : ($urandom_range(0, 29) == 0);
                case ($urandom_range(0, 11))
                    0:       samp = '0;
                    1:       samp = '1;
                    2:       samp = PB'(cur_rate) + PB'($urandom_range(0, 4)) - PB'(2);
                    3:       samp = EXIT_EDGE + PB'($urandom_range(0, 4)) - PB'(2);
                    4:       samp = CAP_EDGE + PB'($urandom_range(0, 4)) - PB'(2);
                    5:       samp = HALF_EDGE + PB'($urandom_range(0, 4)) - PB'(2);
                    6:       samp = PB'($urandom_range(0, 4095));
                    default: samp = PB'($urandom);
                endcase
                push_item(rs, samp);
            end
            wait_drained();
        end

        guard = 0;
        while ((pending.size() != 0 || drop_q.size() != 0) && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending.size() != 0 || drop_q.size() != 0)
        begin
            errors++;
            $display("%0d packets unsent, %0d decisions never returned",
                     pending.size(), drop_q.size());
        end
        if (errors == 0)
            $display("packet_loss_injector_top verification clean");
        else
            $display("packet_loss_injector_top verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(12 * 400000);
        $display("packet_loss_injector_top verification failed");
        $finish;
    end

endmodule
